/* design/dfs_connected_components_core_assert.svh */
// Assertion helpers for the DFS connected components core.
`ifndef DFS_CONNECTED_COMPONENTS_CORE_ASSERT_SVH
`define DFS_CONNECTED_COMPONENTS_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define DFS_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DFS_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

`endif

/* design/dfs_cc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dfs_cc_pkg;

  localparam int VERTEX_W    = 5;
  localparam int COUNT_W     = 6;
  localparam int MAX_RESULTS = 32;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EA_RD,
    ST_EA_WR,
    ST_EB_RD,
    ST_EB_WR,
    ST_ACK,
    ST_SCAN,
    ST_ROOT,
    ST_TOP,
    ST_POP,
    ST_EDGE,
    ST_PUSH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic                result_kind;
    logic                edge_dropped;
    logic [VERTEX_W-1:0] vertex_out;
    logic [VERTEX_W-1:0] component_index;
    logic                last_in_component;
    logic                last_of_run;
  } result_t;

endpackage

`default_nettype wire

/* design/dfs_cc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dfs_cc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [dfs_cc_pkg::VERTEX_W-1:0] edge_first_end;
  logic [dfs_cc_pkg::VERTEX_W-1:0] edge_second_end;

  modport source (output valid, output opcode, output edge_first_end,
                  output edge_second_end, input ready);
  modport sink (input valid, input opcode, input edge_first_end,
                input edge_second_end, output ready);
endinterface

`default_nettype wire

/* design/dfs_cc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dfs_cc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic                          edge_dropped;
  logic [dfs_cc_pkg::VERTEX_W-1:0] vertex_out;
  logic [dfs_cc_pkg::VERTEX_W-1:0] component_index;
  logic                          last_in_component;
  logic                          last_of_run;

  modport source (output valid, output result_kind, output edge_dropped,
                  output vertex_out, output component_index,
                  output last_in_component, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input edge_dropped,
                input vertex_out, input component_index,
                input last_in_component, input last_of_run, output ready);
endinterface

`default_nettype wire

/* design/dfs_connected_components_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dfs_connected_components_core_assert.svh"

// Connected components by depth first search over an edge-loaded graph.
// An edge beat is accepted, appended to both endpoint neighbor lists (each
// append reads the list tail, then writes it, through the head/tail and link
// memories) and acknowledged; a dropped edge skips the appends and is only
// acknowledged. A run beat scans start vertices and walks each component
// through a stack memory, pushing and later popping each visited vertex and
// reading each neighbor entry; a busy output stalls the walk.
// Vertex reports leave one beat behind the walk so the component and run end
// marks ride on the right beat. The run clears the graph when done; no
// clearing pass is needed after reset.
module dfs_connected_components_core #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  dfs_cc_in_if.sink                           in_ch,
  dfs_cc_out_if.source                        out_ch,
  input  wire logic                           cfg_wr_en,
  input  wire logic [dfs_cc_pkg::COUNT_W-1:0] cfg_wr_data
);

  localparam int LD        = 2 * MAX_EDGES;
  localparam int VW        = $clog2(MAX_VERTICES);
  localparam int EW        = $clog2(LD);
  localparam int CW        = $clog2(LD + 1);
  localparam int DW        = $clog2(MAX_VERTICES + 1);
  localparam int START_CAP = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int XW        = dfs_cc_pkg::VERTEX_W;
  localparam int NW        = dfs_cc_pkg::COUNT_W;

  dfs_cc_pkg::state_t  state_r, state_nxt;
  logic [NW-1:0]       vc_r, vc_nxt;
  logic [VW-1:0]       ea_r, ea_nxt, eb_r, eb_nxt;
  logic                drop_r, drop_nxt;
  logic [CW-1:0]       entries_r, entries_nxt;
  logic [MAX_VERTICES-1:0] head_valid_r, head_valid_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [NW-1:0]       starts_r, starts_nxt;
  logic [NW-1:0]       s_r, s_nxt;
  logic [NW-1:0]       comp_r, comp_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic                top_valid_r, top_valid_nxt;
  logic [EW-1:0]       top_cur_r, top_cur_nxt;
  logic [VW-1:0]       w_r, w_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  dfs_cc_pkg::result_t pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  dfs_cc_pkg::result_t out_r, out_nxt;

  // memory ports
  logic              ht_we, ht_re;
  logic [VW-1:0]     ht_waddr, ht_raddr;
  logic [2*EW-1:0]   ht_wdata, ht_rdata;
  logic              tg_we, lk_re;
  logic [EW-1:0]     lk_waddr, lk_raddr;
  logic [VW-1:0]     tg_wdata, tg_rdata;
  logic              nx_we;
  logic [EW-1:0]     nx_waddr;
  logic [EW:0]       nx_wdata, nx_rdata;
  logic              sk_we, sk_re;
  logic [VW-1:0]     sk_waddr, sk_raddr;
  logic [EW:0]       sk_wdata, sk_rdata;

  logic [VW+XW-1:0]  a_ext, b_ext;
  logic [VW+NW-1:0]  s_ext;
  logic [VW-1:0]     s_v;
  logic [VW-1:0]     app_from, app_to;
  logic [EW-1:0]     e_idx;
  logic              out_free, rep_go, rep_fire;
  logic [VW-1:0]     rep_vertex;
  logic [VW+XW-1:0]  rep_ext;
  logic [VW-1:0]     vis_addr;
  logic [DW-1:0]     depth_m1, depth_m2;
  logic              in_run;

  assign a_ext    = {{VW{1'b0}}, in_ch.edge_first_end};
  assign b_ext    = {{VW{1'b0}}, in_ch.edge_second_end};
  assign s_ext    = {{VW{1'b0}}, s_r};
  assign s_v      = s_ext[VW-1:0];
  assign e_idx    = entries_r[EW-1:0];
  assign rep_ext  = {{XW{1'b0}}, rep_vertex};
  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);
  assign in_run   = (in_ch.opcode == dfs_cc_pkg::OP_RUN);

  assign app_from = (state_r == dfs_cc_pkg::ST_EB_RD || state_r == dfs_cc_pkg::ST_EB_WR)
                    ? eb_r : ea_r;
  assign app_to   = (state_r == dfs_cc_pkg::ST_EB_RD || state_r == dfs_cc_pkg::ST_EB_WR)
                    ? ea_r : eb_r;
  assign vis_addr = (state_r == dfs_cc_pkg::ST_SCAN) ? s_v : tg_rdata;

  assign out_free = !out_valid_r || out_ch.ready;
  // a report may wait only when an earlier one must first move to the output
  assign rep_go   = (int'(n_r) >= dfs_cc_pkg::MAX_RESULTS) || !pend_valid_r || out_free;

  always_comb begin
    state_nxt      = state_r;
    vc_nxt         = cfg_wr_en ? cfg_wr_data : vc_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    drop_nxt       = drop_r;
    entries_nxt    = entries_r;
    head_valid_nxt = head_valid_r;
    visited_nxt    = visited_r;
    starts_nxt     = starts_r;
    s_nxt          = s_r;
    comp_nxt       = comp_r;
    n_nxt          = n_r;
    depth_nxt      = depth_r;
    top_valid_nxt  = top_valid_r;
    top_cur_nxt    = top_cur_r;
    w_nxt          = w_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_nxt        = out_r;
    in_ch.ready    = 1'b0;
    rep_fire       = 1'b0;
    rep_vertex     = '0;
    ht_we = 1'b0; ht_re = 1'b0; ht_waddr = app_from; ht_raddr = app_from; ht_wdata = '0;
    tg_we = 1'b0; lk_re = 1'b0; lk_waddr = e_idx; lk_raddr = top_cur_r;
    tg_wdata = app_to;
    nx_we = 1'b0; nx_waddr = e_idx; nx_wdata = '0;
    sk_we = 1'b0; sk_re = 1'b0; sk_waddr = depth_m1[VW-1:0]; sk_raddr = depth_m2[VW-1:0];
    sk_wdata = '0;

    unique case (state_r)
      dfs_cc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_run) begin
            starts_nxt = (int'(vc_r) > START_CAP) ? NW'(START_CAP) : vc_r;
            s_nxt      = '0;
            comp_nxt   = '0;
            n_nxt      = '0;
            state_nxt  = dfs_cc_pkg::ST_SCAN;
          end else begin
            ea_nxt    = a_ext[VW-1:0];
            eb_nxt    = b_ext[VW-1:0];
            drop_nxt  = (int'(in_ch.edge_first_end) >= MAX_VERTICES) ||
                        (int'(in_ch.edge_second_end) >= MAX_VERTICES) ||
                        (int'(entries_r) + 2 > LD);
            state_nxt = ((int'(in_ch.edge_first_end) >= MAX_VERTICES) ||
                         (int'(in_ch.edge_second_end) >= MAX_VERTICES) ||
                         (int'(entries_r) + 2 > LD))
                        ? dfs_cc_pkg::ST_ACK : dfs_cc_pkg::ST_EA_RD;
          end
        end
      end
      dfs_cc_pkg::ST_EA_RD, dfs_cc_pkg::ST_EB_RD: begin
        // fetch the list tail, lay down the new link entry
        ht_re     = 1'b1;
        tg_we     = 1'b1;
        nx_we     = 1'b1;
        nx_wdata  = '0;
        state_nxt = (state_r == dfs_cc_pkg::ST_EA_RD) ? dfs_cc_pkg::ST_EA_WR
                                                     : dfs_cc_pkg::ST_EB_WR;
      end
      dfs_cc_pkg::ST_EA_WR, dfs_cc_pkg::ST_EB_WR: begin
        ht_we = 1'b1;
        if (head_valid_r[app_from]) begin
          nx_we    = 1'b1;
          nx_waddr = ht_rdata[EW-1:0];
          nx_wdata = {1'b1, e_idx};
          ht_wdata = {ht_rdata[2*EW-1:EW], e_idx};
        end else begin
          ht_wdata = {e_idx, e_idx};
          head_valid_nxt[app_from] = 1'b1;
        end
        entries_nxt = entries_r + CW'(1);
        state_nxt   = (state_r == dfs_cc_pkg::ST_EA_WR) ? dfs_cc_pkg::ST_EB_RD
                                                       : dfs_cc_pkg::ST_ACK;
      end
      dfs_cc_pkg::ST_ACK: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_nxt                   = '0;
          out_nxt.result_kind       = dfs_cc_pkg::KIND_ACK;
          out_nxt.edge_dropped      = drop_r;
          out_nxt.last_of_run       = 1'b1;
          state_nxt                 = dfs_cc_pkg::ST_IDLE;
        end
      end
      dfs_cc_pkg::ST_SCAN: begin
        if (s_r >= starts_r) begin
          state_nxt = dfs_cc_pkg::ST_FLUSH;
        end else if (visited_r[vis_addr]) begin
          s_nxt = s_r + NW'(1);
        end else if (rep_go) begin
          visited_nxt[vis_addr] = 1'b1;
          rep_fire   = 1'b1;
          rep_vertex = s_v;
          ht_re      = 1'b1;
          ht_raddr   = s_v;
          state_nxt  = dfs_cc_pkg::ST_ROOT;
        end
      end
      dfs_cc_pkg::ST_ROOT: begin
        top_valid_nxt = head_valid_r[s_v];
        top_cur_nxt   = ht_rdata[2*EW-1:EW];
        depth_nxt     = DW'(1);
        state_nxt     = dfs_cc_pkg::ST_TOP;
      end
      dfs_cc_pkg::ST_TOP: begin
        if (depth_r == '0) begin
          // component done
          if (pend_valid_r) begin
            pend_nxt.last_in_component = 1'b1;
          end
          comp_nxt  = comp_r + NW'(1);
          s_nxt     = s_r + NW'(1);
          state_nxt = dfs_cc_pkg::ST_SCAN;
        end else if (!top_valid_r) begin
          depth_nxt = depth_m1;
          if (depth_r >= DW'(2)) begin
            sk_re     = 1'b1;
            state_nxt = dfs_cc_pkg::ST_POP;
          end
        end else begin
          lk_re     = 1'b1;
          state_nxt = dfs_cc_pkg::ST_EDGE;
        end
      end
      dfs_cc_pkg::ST_POP: begin
        top_valid_nxt = sk_rdata[EW];
        top_cur_nxt   = sk_rdata[EW-1:0];
        state_nxt     = dfs_cc_pkg::ST_TOP;
      end
      dfs_cc_pkg::ST_EDGE: begin
        if (!visited_r[vis_addr] && int'(depth_r) < MAX_VERTICES) begin
          if (rep_go) begin
            top_valid_nxt         = nx_rdata[EW];
            top_cur_nxt           = nx_rdata[EW-1:0];
            visited_nxt[vis_addr] = 1'b1;
            rep_fire              = 1'b1;
            rep_vertex            = tg_rdata;
            sk_we                 = 1'b1;
            sk_wdata              = nx_rdata;
            ht_re                 = 1'b1;
            ht_raddr              = tg_rdata;
            w_nxt                 = tg_rdata;
            state_nxt             = dfs_cc_pkg::ST_PUSH;
          end
        end else begin
          top_valid_nxt = nx_rdata[EW];
          top_cur_nxt   = nx_rdata[EW-1:0];
          state_nxt     = dfs_cc_pkg::ST_TOP;
        end
      end
      dfs_cc_pkg::ST_PUSH: begin
        top_valid_nxt = head_valid_r[w_r];
        top_cur_nxt   = ht_rdata[2*EW-1:EW];
        depth_nxt     = depth_r + DW'(1);
        state_nxt     = dfs_cc_pkg::ST_TOP;
      end
      dfs_cc_pkg::ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt       = 1'b1;
            out_nxt             = pend_r;
            out_nxt.last_of_run = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          head_valid_nxt = '0;
          visited_nxt    = '0;
          entries_nxt    = '0;
          state_nxt      = dfs_cc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dfs_cc_pkg::ST_IDLE;
      end
    endcase

    // the previous report leaves once the next one is known
    if (rep_fire && int'(n_r) < dfs_cc_pkg::MAX_RESULTS) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
      end
      pend_valid_nxt             = 1'b1;
      pend_nxt.result_kind       = dfs_cc_pkg::KIND_VERTEX;
      pend_nxt.edge_dropped      = 1'b0;
      pend_nxt.vertex_out        = rep_ext[XW-1:0];
      pend_nxt.component_index   = comp_r[XW-1:0];
      pend_nxt.last_in_component = 1'b0;
      pend_nxt.last_of_run       = 1'b0;
      n_nxt                      = n_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dfs_cc_pkg::ST_IDLE;
      vc_r         <= NW'(32);
      entries_r    <= '0;
      head_valid_r <= '0;
      visited_r    <= '0;
      n_r          <= '0;
      depth_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vc_r         <= vc_nxt;
      entries_r    <= entries_nxt;
      head_valid_r <= head_valid_nxt;
      visited_r    <= visited_nxt;
      n_r          <= n_nxt;
      depth_r      <= depth_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r        <= ea_nxt;
    eb_r        <= eb_nxt;
    drop_r      <= drop_nxt;
    starts_r    <= starts_nxt;
    s_r         <= s_nxt;
    comp_r      <= comp_nxt;
    top_valid_r <= top_valid_nxt;
    top_cur_r   <= top_cur_nxt;
    w_r         <= w_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_kind       = out_r.result_kind;
  assign out_ch.edge_dropped      = out_r.edge_dropped;
  assign out_ch.vertex_out        = out_r.vertex_out;
  assign out_ch.component_index   = out_r.component_index;
  assign out_ch.last_in_component = out_r.last_in_component;
  assign out_ch.last_of_run       = out_r.last_of_run;

  // per-vertex list head and tail
  dfs_cc_ram #(.WIDTH(2 * EW), .DEPTH(MAX_VERTICES)) u_head_tail (
    .clk   (clk),
    .we    (ht_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .re    (ht_re),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  // neighbor vertex of each link entry
  dfs_cc_ram #(.WIDTH(VW), .DEPTH(LD)) u_link_target (
    .clk   (clk),
    .we    (tg_we),
    .waddr (lk_waddr),
    .wdata (tg_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (tg_rdata)
  );

  // next pointer with its valid bit
  dfs_cc_ram #(.WIDTH(EW + 1), .DEPTH(LD)) u_link_next (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (nx_rdata)
  );

  // stack entries below the top; the top cursor lives in registers
  dfs_cc_ram #(.WIDTH(EW + 1), .DEPTH(MAX_VERTICES)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  `DFS_ASSERT_ALWAYS(a_depth_bound, clk, rst_n, int'(depth_r) <= MAX_VERTICES, "stack overflow")
  `DFS_ASSERT_ALWAYS(a_entries_bound, clk, rst_n, int'(entries_r) <= LD, "link store overrun")
  `DFS_ASSERT_IMPLY(a_pend_counted, clk, rst_n, pend_valid_r, n_r != '0, "pending beat uncounted")
  `DFS_ASSERT_IMPLY(a_idle_no_pend, clk, rst_n, state_r == dfs_cc_pkg::ST_IDLE, !pend_valid_r, "report left behind")

endmodule

`default_nettype wire

/* design/dfs_cc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dfs_cc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
